[hw/rtl/ghg_pkg.sv]
`default_nettype none

package ghg_pkg;

    localparam int COORD_W  = 6;
    localparam int DIM_W    = 7;
    localparam int HEIGHT_W = 32;
    localparam int SLOPE_W  = 32;
    localparam int INV_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Y = 8'd3;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_BAD   = 2'd1,
        K_QUERY = 2'd2
    } t_kind;

    // per-word command from the front to the back
    typedef struct packed {
        t_kind kind;
        logic  hx;   // x neighbors two cells apart
        logic  hy;   // y neighbors two cells apart
    } t_cmd;

endpackage

`default_nettype wire

[hw/rtl/ghg_ram.sv]
`default_nettype none

module ghg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

[hw/rtl/ghg_front.sv]
`default_nettype none

module ghg_front import ghg_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    parameter int AW       = 12
) (
    input  wire logic               i_valid,
    input  wire logic               i_mode,
    input  wire logic [COORD_W-1:0] i_col,
    input  wire logic [COORD_W-1:0] i_row,
    input  wire logic [DIM_W-1:0]   i_grid_cols,
    input  wire logic [DIM_W-1:0]   i_grid_rows,
    output logic                    o_push,
    output t_cmd                    o_cmd,
    output logic [AW-1:0]           o_addr_a,
    output logic [AW-1:0]           o_addr_b,
    output logic [AW-1:0]           o_addr_c,
    output logic [AW-1:0]           o_addr_d
);

    localparam int LW = 11;

    function automatic logic [AW-1:0] addr_of(input logic [DIM_W-1:0] x,
                                              input logic [DIM_W-1:0] y);
        logic [31:0] t;
        t = 32'(y) * 32'(MAX_COLS) + 32'(x);
        return t[AW-1:0];
    endfunction

    logic [DIM_W-1:0] nc, nr, c7, r7, c_inc, r_inc, cm, cp, rm, rp;
    logic             bad, in_store;

    always_comb begin
        nc = (LW'(i_grid_cols) < LW'(MAX_COLS)) ? i_grid_cols : DIM_W'(MAX_COLS);
        nr = (LW'(i_grid_rows) < LW'(MAX_ROWS)) ? i_grid_rows : DIM_W'(MAX_ROWS);
        c7 = DIM_W'(i_col);
        r7 = DIM_W'(i_row);
        c_inc = c7 + DIM_W'(1);
        r_inc = r7 + DIM_W'(1);
        cm = (c7 != '0) ? c7 - DIM_W'(1) : '0;
        rm = (r7 != '0) ? r7 - DIM_W'(1) : '0;
        cp = (c_inc < nc) ? c_inc : nc - DIM_W'(1);
        rp = (r_inc < nr) ? r_inc : nr - DIM_W'(1);
        bad = (c7 >= nc) || (r7 >= nr);
        in_store = (LW'(i_col) < LW'(MAX_COLS)) && (LW'(i_row) < LW'(MAX_ROWS));

        o_cmd.hx = (cp - cm) == DIM_W'(2);
        o_cmd.hy = (rp - rm) == DIM_W'(2);
        if (i_mode == MODE_LOAD) begin
            o_cmd.kind = K_LOAD;
        end else if (bad) begin
            o_cmd.kind = K_BAD;
        end else begin
            o_cmd.kind = K_QUERY;
        end

        // loads outside the store are dropped here
        o_push   = i_valid && (i_mode == MODE_QUERY || in_store);
        o_addr_a = (i_mode == MODE_LOAD) ? addr_of(c7, r7) : addr_of(cp, r7);
        o_addr_b = addr_of(cm, r7);
        o_addr_c = addr_of(c7, rp);
        o_addr_d = addr_of(c7, rm);
    end

endmodule

`default_nettype wire

[hw/rtl/ghg_queue.sv]
`default_nettype none

module ghg_queue #(
    parameter int WIDTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_in_ready,
    input  wire logic             i_pop,
    output logic                  o_out_valid,
    output logic      [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic             push, pop;

    assign o_in_ready  = r_cnt != 2'd2;
    assign o_out_valid = r_cnt != 2'd0;
    assign o_data      = r_mem[r_rp];
    assign push        = i_push && o_in_ready;
    assign pop         = i_pop && o_out_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ghg_back.sv]
`default_nettype none

module ghg_back import ghg_pkg::*; #(
    parameter int AW    = 12,
    parameter int DEPTH = 4096
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_valid,
    input  wire t_cmd                i_cmd,
    input  wire logic [AW-1:0]       i_addr_a,
    input  wire logic [AW-1:0]       i_addr_b,
    input  wire logic [AW-1:0]       i_addr_c,
    input  wire logic [AW-1:0]       i_addr_d,
    input  wire logic [HEIGHT_W-1:0] i_height,
    input  wire logic [INV_W-1:0]    i_inv_x,
    input  wire logic [INV_W-1:0]    i_inv_y,
    output logic                     o_q_pop,
    input  wire logic                i_m_tready,
    output logic                     o_m_tvalid,
    output logic      [SLOPE_W-1:0]  o_slope_x,
    output logic      [SLOPE_W-1:0]  o_slope_y,
    output logic                     o_sat,
    output logic                     o_bad
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RDY  = 6'b000010,
        S_DIFY = 6'b000100,
        S_MUL  = 6'b001000,
        S_SUM  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0]       r_addr_c, r_addr_d;
    logic                r_hx, r_hy, r_axis;
    logic [31:0]         r_mag_x, r_mag_y;
    logic                r_neg_x, r_neg_y;
    logic [47:0]         r_pp_lo, r_pp_hi;
    logic [63:0]         r_prod;
    logic [SLOPE_W-1:0]  r_sx;
    logic                r_sat_x;
    logic                r_out_valid;

    logic                out_free, ram_we, load_out;
    logic [AW-1:0]       ra0, ra1;
    logic [HEIGHT_W-1:0] rd0, rd1;
    logic [32:0]         diff, ndiff;
    logic                dneg;
    logic [31:0]         dmag, mag_sel;
    logic [INV_W-1:0]    inv_sel;
    logic [47:0]         pp_lo, pp_hi, q;
    logic [48:0]         qn;
    logic                h_sel, neg_sel, rem, sat_now;
    logic [SLOPE_W-1:0]  slope;

    ghg_ram #(
        .WIDTH(HEIGHT_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_addr_a),
        .i_wdata (i_height),
        .i_raddr0(ra0),
        .i_raddr1(ra1),
        .o_rdata0(rd0),
        .o_rdata1(rd1)
    );

    always_comb begin
        out_free = !r_out_valid || i_m_tready;
        o_q_pop  = (r_state == S_IDLE) && i_q_valid && (i_cmd.kind != K_BAD || out_free);
        ram_we   = o_q_pop && i_cmd.kind == K_LOAD;
        ra0      = (r_state == S_IDLE) ? i_addr_a : r_addr_c;
        ra1      = (r_state == S_IDLE) ? i_addr_b : r_addr_d;

        // upper neighbor minus lower neighbor, kept as sign and magnitude
        diff  = {rd0[HEIGHT_W-1], rd0} - {rd1[HEIGHT_W-1], rd1};
        ndiff = -diff;
        dneg  = diff[32];
        dmag  = dneg ? ndiff[31:0] : diff[31:0];

        mag_sel = r_axis ? r_mag_y : r_mag_x;
        inv_sel = r_axis ? i_inv_y : i_inv_x;
        pp_lo   = mag_sel[15:0] * inv_sel;
        pp_hi   = mag_sel[31:16] * inv_sel;

        h_sel   = r_axis ? r_hy : r_hx;
        neg_sel = r_axis ? r_neg_y : r_neg_x;
        q       = h_sel ? {1'b0, r_prod[63:17]} : r_prod[63:16];
        rem     = h_sel ? (|r_prod[16:0]) : (|r_prod[15:0]);
        qn      = {1'b0, q} + 49'(rem);
        if (neg_sel) begin
            sat_now = qn > 49'h0_8000_0000;
            slope   = sat_now ? 32'h8000_0000 : (32'd0 - qn[31:0]);
        end else begin
            sat_now = q > 48'h7FFF_FFFF;
            slope   = sat_now ? 32'h7FFF_FFFF : q[31:0];
        end

        load_out = (o_q_pop && i_cmd.kind == K_BAD) ||
                   (r_state == S_FIN && r_axis && out_free);

        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop && i_cmd.kind == K_QUERY) begin
                    n_state = S_RDY;
                end
            end
            S_RDY:  n_state = S_DIFY;
            S_DIFY: n_state = S_MUL;
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_FIN;
            S_FIN: begin
                if (!r_axis) begin
                    n_state = S_MUL;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_addr_c <= i_addr_c;
                r_addr_d <= i_addr_d;
                r_hx     <= i_cmd.hx;
                r_hy     <= i_cmd.hy;
            end
            S_RDY: begin
                r_mag_x <= dmag;
                r_neg_x <= dneg;
            end
            S_DIFY: begin
                r_mag_y <= dmag;
                r_neg_y <= dneg;
                r_axis  <= 1'b0;
            end
            S_MUL: begin
                r_pp_lo <= pp_lo;
                r_pp_hi <= pp_hi;
            end
            S_SUM: begin
                r_prod <= {r_pp_hi, 16'd0} + {16'd0, r_pp_lo};
            end
            S_FIN: begin
                if (!r_axis) begin
                    r_sx    <= slope;
                    r_sat_x <= sat_now;
                    r_axis  <= 1'b1;
                end
            end
            default: ;
        endcase

        if (load_out) begin
            if (r_state == S_FIN) begin
                o_slope_x <= r_sx;
                o_slope_y <= slope;
                o_sat     <= r_sat_x | sat_now;
                o_bad     <= 1'b0;
            end else begin
                o_slope_x <= '0;
                o_slope_y <= '0;
                o_sat     <= 1'b0;
                o_bad     <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

`ifndef SYNTHESIS
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == S_IDLE)
        else $error("height write outside idle");

    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_cmd.kind == K_QUERY) |=> r_state == S_RDY)
        else $error("query pop did not start the read sequence");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_axis && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished query not presented");
`endif

endmodule

`default_nettype wire

[hw/rtl/grid_height_gradient.sv]
`default_nettype none

// channel   dir  handshake                       payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata {height_in,row,col}, tuser mode
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata {slope_y,slope_x}, tuser {bad,sat}
// cfg       in   i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
// Back end: a load writes the height memory as it is popped; a query inside the
// grid does two dual-port height reads, then the shared multiply/round unit runs
// once per axis; a query outside the grid loads a bad-index result directly.
// A 2-word queue separates input acceptance from the back end.
// Reset is synchronous; height memory contents stay undefined, no clear pass.
// Output is registered; a stalled result holds the back end, input stalls once the queue is full.

module grid_height_gradient import ghg_pkg::*; #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,  // col[5:0], row[11:6], height_in[43:12]
    input  wire logic                  i_s_axis_tuser,  // mode
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [M_TDATA_W-1:0]  o_m_axis_tdata,  // slope_x[31:0], slope_y[63:32]
    output logic      [M_TUSER_W-1:0]  o_m_axis_tuser,  // saturated[0], bad_index[1]
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]           i_cfg_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = $bits(t_cmd) + 4 * AW + HEIGHT_W;

    logic [DIM_W-1:0] r_grid_cols, r_grid_rows;
    logic [INV_W-1:0] r_inv_x, r_inv_y;

    t_cmd                f_cmd, q_cmd;
    logic                f_push, q_ready, q_valid, q_pop, sat, bad;
    logic [AW-1:0]       f_a, f_b, f_c, f_d, q_a, q_b, q_c, q_d;
    logic [HEIGHT_W-1:0] q_height;
    logic [QW-1:0]       q_in, q_out;
    logic [SLOPE_W-1:0]  slope_x, slope_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= 7'd64;
            r_grid_rows <= 7'd64;
            r_inv_x     <= 32'd65536;
            r_inv_y     <= 32'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GRID_COLS:  r_grid_cols <= i_cfg_data[DIM_W-1:0];
                REG_GRID_ROWS:  r_grid_rows <= i_cfg_data[DIM_W-1:0];
                REG_INV_STEP_X: r_inv_x     <= i_cfg_data;
                REG_INV_STEP_Y: r_inv_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ghg_front #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS),
        .AW      (AW)
    ) u_front (
        .i_valid    (i_s_axis_tvalid && o_s_axis_tready),
        .i_mode     (i_s_axis_tuser),
        .i_col      (i_s_axis_tdata[5:0]),
        .i_row      (i_s_axis_tdata[11:6]),
        .i_grid_cols(r_grid_cols),
        .i_grid_rows(r_grid_rows),
        .o_push     (f_push),
        .o_cmd      (f_cmd),
        .o_addr_a   (f_a),
        .o_addr_b   (f_b),
        .o_addr_c   (f_c),
        .o_addr_d   (f_d)
    );

    assign q_in = {f_cmd, f_a, f_b, f_c, f_d, i_s_axis_tdata[43:12]};
    assign o_s_axis_tready = q_ready;

    ghg_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (f_push),
        .i_data     (q_in),
        .o_in_ready (q_ready),
        .i_pop      (q_pop),
        .o_out_valid(q_valid),
        .o_data     (q_out)
    );

    assign {q_cmd, q_a, q_b, q_c, q_d, q_height} = q_out;

    ghg_back #(
        .AW   (AW),
        .DEPTH(DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .i_addr_a  (q_a),
        .i_addr_b  (q_b),
        .i_addr_c  (q_c),
        .i_addr_d  (q_d),
        .i_height  (q_height),
        .i_inv_x   (r_inv_x),
        .i_inv_y   (r_inv_y),
        .o_q_pop   (q_pop),
        .i_m_tready(i_m_axis_tready),
        .o_m_tvalid(o_m_axis_tvalid),
        .o_slope_x (slope_x),
        .o_slope_y (slope_y),
        .o_sat     (sat),
        .o_bad     (bad)
    );

    assign o_m_axis_tdata = {slope_y, slope_x};
    assign o_m_axis_tuser = {bad, sat};

endmodule

`default_nettype wire
